FILE: hw/rtl/agpe_pkg.sv
// shared types, constants and colour blend functions for the glyph pixel expander
`default_nettype none

package agpe_pkg;

    localparam int unsigned PIXELS_PER_BYTE = 4;
    localparam int unsigned COUNT_W         = 3;
    localparam int unsigned QUEUE_DEPTH     = 2;

    localparam int unsigned RED_POS   = 11;
    localparam int unsigned GREEN_POS = 5;
    localparam logic [7:0]  DIV3_RECIP = 8'd171;

    typedef enum logic [1:0] {
        LEVEL_BG    = 2'd0,
        LEVEL_LIGHT = 2'd1,
        LEVEL_HEAVY = 2'd2,
        LEVEL_FG    = 2'd3
    } agpe_level_t;

    typedef enum logic {
        REG_FOREGROUND = 1'b0,
        REG_BACKGROUND = 1'b1
    } agpe_reg_idx_t;

    typedef struct packed {
        logic [7:0]         levels;
        logic [COUNT_W-1:0] count;
        logic               final_byte;
    } agpe_entry_t;

    // floor(x / 3) for x below 256 via reciprocal 171 / 512
    function automatic logic [6:0] div3(input logic [7:0] x);
        logic [15:0] prod;
        begin
            prod = x * DIV3_RECIP;
            return prod[15:9];
        end
    endfunction

    // (light + 2 * heavy) / 3 on one channel of up to six bits
    function automatic logic [5:0] mix_channel(input logic [5:0] light,
                                               input logic [5:0] heavy);
        logic [7:0] sum;
        logic [6:0] q;
        begin
            sum = {2'b00, light} + {1'b0, heavy, 1'b0};
            q   = div3(sum);
            return q[5:0];
        end
    endfunction

    function automatic logic [15:0] shade(input agpe_level_t level,
                                          input logic [15:0] fg,
                                          input logic [15:0] bg);
        logic [5:0]  r;
        logic [5:0]  g;
        logic [5:0]  b;
        logic [15:0] res;
        begin
            r   = '0;
            g   = '0;
            b   = '0;
            res = bg;
            case (level)
                LEVEL_BG: res = bg;
                LEVEL_FG: res = fg;
                LEVEL_LIGHT:
                begin
                    r   = mix_channel({1'b0, fg[15:11]}, {1'b0, bg[15:11]});
                    g   = mix_channel(fg[10:5], bg[10:5]);
                    b   = mix_channel({1'b0, fg[4:0]}, {1'b0, bg[4:0]});
                    res = {r[4:0], g, b[4:0]};
                end
                LEVEL_HEAVY:
                begin
                    r   = mix_channel({1'b0, bg[15:11]}, {1'b0, fg[15:11]});
                    g   = mix_channel(bg[10:5], fg[10:5]);
                    b   = mix_channel({1'b0, bg[4:0]}, {1'b0, fg[4:0]});
                    res = {r[4:0], g, b[4:0]};
                end
                default: res = bg;
            endcase
            return res;
        end
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/agpe_front.sv
// front end: takes bytes, clamps the pixel count and drops empty bytes
`default_nettype none

module agpe_front
    import agpe_pkg::*;
(
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         packed_levels,
    input  wire logic [COUNT_W-1:0] valid_pixels,
    input  wire logic               glyph_final_byte,
    output logic                    push,
    output agpe_entry_t             push_entry,
    input  wire logic               q_full
);

    logic [COUNT_W-1:0] clamped;

    always_comb
    begin
        if (valid_pixels > COUNT_W'(PIXELS_PER_BYTE))
        begin
            clamped = COUNT_W'(PIXELS_PER_BYTE);
        end
        else
        begin
            clamped = valid_pixels;
        end
    end

    assign in_ready = !q_full;

    // an item with no pixels is taken and forgotten
    assign push = in_valid && !q_full && (clamped != '0);

    assign push_entry.levels     = packed_levels;
    assign push_entry.count      = clamped;
    assign push_entry.final_byte = glyph_final_byte;

endmodule

`default_nettype wire

FILE: hw/rtl/agpe_queue.sv
// short queue of classified bytes between front and back
`default_nettype none

module agpe_queue
    import agpe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire agpe_entry_t push_entry,
    output logic             full,
    input  wire logic        pop,
    output logic             q_valid,
    output agpe_entry_t      q_entry
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    agpe_entry_t         slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    fill_reg;
    logic [CNT_W-1:0]    fill_next;

    assign full    = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_entry = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue read while empty");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill count out of range");

endmodule

`default_nettype wire

FILE: hw/rtl/agpe_back.sv
// back end: walks the pixels of one byte, blends and registers each result
`default_nettype none

module agpe_back
    import agpe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [15:0] fg_color,
    input  wire logic [15:0] bg_color,
    input  wire logic        q_valid,
    input  wire agpe_entry_t q_entry,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      pixel_color,
    output logic             byte_done,
    output logic             glyph_done
);

    logic [7:0]         cur_levels_reg;
    logic [7:0]         cur_levels_next;
    logic [COUNT_W-1:0] cur_left_reg;
    logic [COUNT_W-1:0] cur_left_next;
    logic               cur_final_reg;
    logic               cur_final_next;
    logic               cur_valid_reg;
    logic               cur_valid_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [15:0]        pixel_color_reg;
    logic [15:0]        pixel_color_next;
    logic               byte_done_reg;
    logic               byte_done_next;
    logic               glyph_done_reg;
    logic               glyph_done_next;

    logic               slot_free;
    logic               emit;
    logic               last_pixel;
    logic [15:0]        colour;

    assign slot_free  = !out_valid_reg || out_ready;
    assign emit       = cur_valid_reg && slot_free;
    assign last_pixel = (cur_left_reg == COUNT_W'(1));
    // next byte loads as the current one hands over its last pixel
    assign pop        = q_valid && (!cur_valid_reg || (emit && last_pixel));
    assign colour     = shade(agpe_level_t'(cur_levels_reg[7:6]), fg_color, bg_color);

    always_comb
    begin
        cur_levels_next  = cur_levels_reg;
        cur_left_next    = cur_left_reg;
        cur_final_next   = cur_final_reg;
        cur_valid_next   = cur_valid_reg;
        out_valid_next   = out_valid_reg;
        pixel_color_next = pixel_color_reg;
        byte_done_next   = byte_done_reg;
        glyph_done_next  = glyph_done_reg;

        if (pop)
        begin
            cur_levels_next = q_entry.levels;
            cur_left_next   = q_entry.count;
            cur_final_next  = q_entry.final_byte;
            cur_valid_next  = 1'b1;
        end
        else if (emit)
        begin
            cur_levels_next = {cur_levels_reg[5:0], 2'b00};
            cur_left_next   = cur_left_reg - 1'b1;
            cur_valid_next  = !last_pixel;
        end

        if (emit)
        begin
            out_valid_next   = 1'b1;
            pixel_color_next = colour;
            byte_done_next   = last_pixel;
            glyph_done_next  = last_pixel && cur_final_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_levels_reg  <= cur_levels_next;
        cur_left_reg    <= cur_left_next;
        cur_final_reg   <= cur_final_next;
        pixel_color_reg <= pixel_color_next;
        byte_done_reg   <= byte_done_next;
        glyph_done_reg  <= glyph_done_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_color = pixel_color_reg;
    assign byte_done   = byte_done_reg;
    assign glyph_done  = glyph_done_reg;

    a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (cur_left_reg != '0 && cur_left_reg <= COUNT_W'(PIXELS_PER_BYTE)))
        else $error("pixel count of current byte out of range");

    a_glyph_on_byte_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && glyph_done_reg) |-> byte_done_reg)
        else $error("glyph end without byte end");

    a_pop_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && cur_valid_reg) |-> (emit && last_pixel))
        else $error("byte loaded over unfinished one");

endmodule

`default_nettype wire

FILE: hw/rtl/antialiased_glyph_pixel_expander_unit.sv
// top level of the antialiased glyph pixel expander
// Usage:
//   each input item is one glyph bitmap byte with four 2-bit coverage levels
//   (first pixel in bits 7:6), a pixel count and an end-of-glyph flag
//   every valid pixel of the byte comes out as one RGB565 item on the output
//   channel, in pixel order, with byte_done on the last pixel of the byte and
//   glyph_done on the last pixel of a final byte
//   counts above four are treated as four; a byte with count zero is taken
//   and gives no item
//   colours are set through the write port: index 0 foreground, 1 background
//   a byte passes through the queue and the current byte register before
//   its first pixel is registered at the output; throughput: one pixel a cycle
//   while the receiver takes them, set by the single pixel blend unit
//   a two-entry byte queue and the output register let input keep flowing
//   while the receiver stalls; input ready drops only when the queue is full
//   reset empties the queue and output and sets white on black
`default_nettype none

module antialiased_glyph_pixel_expander_unit
    import agpe_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic               cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         packed_levels,
    input  wire logic [COUNT_W-1:0] valid_pixels,
    input  wire logic               glyph_final_byte,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [15:0]             pixel_color,
    output logic                    byte_done,
    output logic                    glyph_done
);

    logic [15:0] fg_color_reg;
    logic [15:0] fg_color_next;
    logic [15:0] bg_color_reg;
    logic [15:0] bg_color_next;

    logic        push;
    agpe_entry_t push_entry;
    logic        q_full;
    logic        pop;
    logic        q_valid;
    agpe_entry_t q_entry;

    always_comb
    begin
        fg_color_next = fg_color_reg;
        bg_color_next = bg_color_reg;
        if (cfg_write)
        begin
            case (agpe_reg_idx_t'(cfg_index))
                REG_FOREGROUND: fg_color_next = cfg_data;
                REG_BACKGROUND: bg_color_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_color_reg <= 16'hFFFF;
            bg_color_reg <= 16'h0000;
        end
        else
        begin
            fg_color_reg <= fg_color_next;
            bg_color_reg <= bg_color_next;
        end
    end

    agpe_front u_front (
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .packed_levels    (packed_levels),
        .valid_pixels     (valid_pixels),
        .glyph_final_byte (glyph_final_byte),
        .push             (push),
        .push_entry       (push_entry),
        .q_full           (q_full)
    );

    agpe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    agpe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .fg_color    (fg_color_reg),
        .bg_color    (bg_color_reg),
        .q_valid     (q_valid),
        .q_entry     (q_entry),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_color (pixel_color),
        .byte_done   (byte_done),
        .glyph_done  (glyph_done)
    );

endmodule

`default_nettype wire
